FILE: sv/fcfs_pkg.sv
// Package: shared types and constants for the FCFS schedule metrics block.
package fcfs_pkg;

    localparam int MAX_PROCESSES_DEF = 32;
    localparam int TIME_W = 16;
    localparam int WIDE_W = 22;
    localparam int SUM_W  = 28;
    localparam int AVG_W  = 30;
    localparam int ID_W   = 6;
    localparam int FRAC_W = 8;
    localparam int DIVD_W = SUM_W + FRAC_W;

    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_time;
        logic              last_process;
    } fcfs_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   process_id;
        logic [TIME_W-1:0] arrival_out;
        logic [TIME_W-1:0] burst_out;
        logic [WIDE_W-1:0] completion_time;
        logic [WIDE_W-1:0] waiting_time;
        logic [WIDE_W-1:0] turnaround_time;
        logic [AVG_W-1:0]  average_waiting;
        logic [AVG_W-1:0]  average_turnaround;
        logic              final_row;
        logic              overflow_seen;
    } fcfs_out_t;

endpackage

FILE: sv/fcfs_schedule_metrics_top.sv
// Top level: loads a process set, orders it by arrival and computes FCFS metrics.
//
//  Channel | Signals                     | Direction | Payload
//  --------+-----------------------------+-----------+-------------------------
//  item    | item_valid, item_ready      | in        | fcfs_in_t  (one process)
//  row     | row_valid, row_ready        | out       | fcfs_out_t (one result)
//
// Loading takes one request per cycle while the block sits idle. The request marked
// as last starts the computation: each result row needs a scan of the stored set
// through the single memory read port (a read and a compare state per stored entry),
// the completion, turnaround and waiting steps and an offer that holds until taken;
// a bit-serial restoring divider then forms the two averages for the last row.
// Reset is asynchronous and clears the set; the process store is not cleared, as
// only entries written in the current set are read. A stalled row simply holds.
module fcfs_schedule_metrics_top #(
    parameter int MAX_PROCESSES = fcfs_pkg::MAX_PROCESSES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  fcfs_pkg::fcfs_in_t  item,
    output logic                row_valid,
    input  logic                row_ready,
    output fcfs_pkg::fcfs_out_t row
);
    import fcfs_pkg::*;

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int KW = TIME_W + IW;
    localparam int DCW = $clog2(DIVD_W);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_CT, S_TAT, S_WT, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    // Process store: arrival in the upper half, burst in the lower half.
    logic [2*TIME_W-1:0] mem [MAX_PROCESSES];
    logic [2*TIME_W-1:0] rd_q_reg;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     emitted_reg;
    logic              dropped_reg;
    logic [IW-1:0]     scan_idx_reg;
    logic              have_best_reg;
    logic              have_last_reg;
    logic [KW-1:0]     best_key_reg;
    logic [KW-1:0]     last_key_reg;
    logic [TIME_W-1:0] best_burst_reg;
    logic [WIDE_W-1:0] cpu_reg;
    logic [WIDE_W-1:0] ct_reg;
    logic [WIDE_W-1:0] tat_reg;
    logic [WIDE_W-1:0] wt_reg;
    logic [SUM_W-1:0]  wsum_reg;
    logic [SUM_W-1:0]  tsum_reg;
    logic              final_reg;
    logic [DIVD_W-1:0] divq_reg;
    logic [CW-1:0]     rem_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic              dsel_reg;
    logic [AVG_W-1:0]  avgw_reg;
    logic [AVG_W-1:0]  avgt_reg;

    logic              item_acc;
    logic              store_ok;
    logic [KW-1:0]     cand_key;
    logic              cand_better;
    logic [TIME_W-1:0] best_arr;
    logic [WIDE_W-1:0] start_time;
    logic [WIDE_W-1:0] wt_next;
    logic [SUM_W-1:0]  wsum_next;
    logic [SUM_W-1:0]  tsum_next;
    logic [CW:0]       rem_shift;
    logic              rem_ge;
    logic [CW-1:0]     rem_next;
    logic [DIVD_W-1:0] divq_next;
    logic [AVG_W-1:0]  avg_sat;

    assign item_ready = (state_reg == S_IDLE);
    assign row_valid  = (state_reg == S_OUT);
    assign item_acc   = item_valid && item_ready;
    assign store_ok   = (count_reg < CW'(MAX_PROCESSES));

    // Candidate is the next in stable order: key is {arrival, load index}.
    assign cand_key    = {rd_q_reg[2*TIME_W-1:TIME_W], scan_idx_reg};
    assign cand_better = (!have_last_reg || (cand_key > last_key_reg))
                      && (!have_best_reg || (cand_key < best_key_reg));
    assign best_arr    = best_key_reg[KW-1:IW];

    assign start_time = (cpu_reg < WIDE_W'(best_arr)) ? WIDE_W'(best_arr) : cpu_reg;
    assign wt_next    = tat_reg - WIDE_W'(best_burst_reg);
    assign wsum_next  = wsum_reg + SUM_W'(wt_next);
    assign tsum_next  = tsum_reg + SUM_W'(tat_reg);

    // One restoring division step per cycle.
    assign rem_shift = {rem_reg, divq_reg[DIVD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, n_reg});
    assign rem_next  = rem_ge ? CW'(rem_shift - {1'b0, n_reg}) : CW'(rem_shift);
    assign divq_next = {divq_reg[DIVD_W-2:0], rem_ge};
    assign avg_sat   = (divq_next[DIVD_W-1:AVG_W] != '0) ? '1 : divq_next[AVG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (item_acc && store_ok)
        begin
            mem[count_reg[IW-1:0]] <= {item.arrival_time, item.burst_time};
        end
        rd_q_reg <= mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            emitted_reg   <= '0;
            dropped_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            have_best_reg <= 1'b0;
            have_last_reg <= 1'b0;
            cpu_reg       <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            final_reg     <= 1'b0;
            dcnt_reg      <= '0;
            dsel_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_acc)
                    begin
                        if (store_ok)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (item.last_process)
                        begin
                            n_reg         <= store_ok ? count_reg + 1'b1 : count_reg;
                            emitted_reg   <= '0;
                            scan_idx_reg  <= '0;
                            have_best_reg <= 1'b0;
                            have_last_reg <= 1'b0;
                            state_reg     <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (cand_better)
                    begin
                        best_key_reg   <= cand_key;
                        best_burst_reg <= rd_q_reg[TIME_W-1:0];
                        have_best_reg  <= 1'b1;
                    end
                    if (CW'(scan_idx_reg) == n_reg - 1'b1)
                    begin
                        state_reg <= S_CT;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        state_reg    <= S_SCAN_RD;
                    end
                end
                S_CT:
                begin
                    ct_reg        <= start_time + WIDE_W'(best_burst_reg);
                    cpu_reg       <= start_time + WIDE_W'(best_burst_reg);
                    last_key_reg  <= best_key_reg;
                    have_last_reg <= 1'b1;
                    state_reg     <= S_TAT;
                end
                S_TAT:
                begin
                    tat_reg   <= ct_reg - WIDE_W'(best_arr);
                    state_reg <= S_WT;
                end
                S_WT:
                begin
                    wt_reg    <= wt_next;
                    wsum_reg  <= wsum_next;
                    tsum_reg  <= tsum_next;
                    final_reg <= (emitted_reg == n_reg - 1'b1);
                    if (emitted_reg == n_reg - 1'b1)
                    begin
                        divq_reg  <= {wsum_next, FRAC_W'(0)};
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        dsel_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (dcnt_reg == DCW'(DIVD_W - 1))
                    begin
                        dcnt_reg <= '0;
                        rem_reg  <= '0;
                        if (!dsel_reg)
                        begin
                            avgw_reg <= avg_sat;
                            divq_reg <= {tsum_reg, FRAC_W'(0)};
                            dsel_reg <= 1'b1;
                        end
                        else
                        begin
                            avgt_reg  <= avg_sat;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        divq_reg <= divq_next;
                        rem_reg  <= rem_next;
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (row_ready)
                    begin
                        if (final_reg)
                        begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            cpu_reg     <= '0;
                            wsum_reg    <= '0;
                            tsum_reg    <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            emitted_reg   <= emitted_reg + 1'b1;
                            scan_idx_reg  <= '0;
                            have_best_reg <= 1'b0;
                            state_reg     <= S_SCAN_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        row.process_id         = ID_W'(best_key_reg[IW-1:0]) + 1'b1;
        row.arrival_out        = best_arr;
        row.burst_out          = best_burst_reg;
        row.completion_time    = ct_reg;
        row.waiting_time       = wt_reg;
        row.turnaround_time    = tat_reg;
        row.average_waiting    = final_reg ? avgw_reg : '0;
        row.average_turnaround = final_reg ? avgt_reg : '0;
        row.final_row          = final_reg;
        row.overflow_seen      = dropped_reg;
    end

endmodule

FILE: sv/fcfs_checker.sv
// Checker: port-level properties of the FCFS schedule metrics block, with its bind.
module fcfs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                row_valid,
    input logic                row_ready,
    input fcfs_pkg::fcfs_out_t row
);
    import fcfs_pkg::*;

    // A pending row holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_ready |=> row_valid && $stable(row))
        else $error("row changed while stalled");

    // An offered request stays offered until the block takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid)
        else $error("request withdrawn before acceptance");

    // The block never loads while a row is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && row_valid))
        else $error("loading and result phases overlap");

    // Averages only appear on the last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row.final_row |->
            row.average_waiting == '0 && row.average_turnaround == '0)
        else $error("average on a non-final row");

    // After the last row is taken the block is ready for a new set.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && row.final_row |=> item_ready)
        else $error("not ready after set end");

endmodule

bind fcfs_schedule_metrics_top fcfs_checker u_fcfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .row        (row)
);
